@@ hdl/tls_client_hello_sni_extractor_top_defines.svh @@
// Assertion macros for the SNI extractor checker.
`ifndef TLS_CLIENT_HELLO_SNI_EXTRACTOR_TOP_DEFINES_SVH
`define TLS_CLIENT_HELLO_SNI_EXTRACTOR_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SNI_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define SNI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ hdl/sni_pkg.sv @@
// Package: payload types, parse phases and status codes of the SNI extractor.
`default_nettype none
package sni_pkg;
  typedef struct packed {
    logic [7:0] record_byte;
    logic       last_byte;
  } sni_in_t;

  typedef struct packed {
    logic [7:0] name_char;
    logic       char_valid;
    logic       name_done;
    logic       name_ok;
    logic       record_done;
    logic [2:0] status;
  } sni_out_t;

  typedef enum logic [4:0] {
    PH_H0, PH_H1, PH_H2, PH_H3, PH_H4,
    PH_HS_TYPE, PH_HS_L0, PH_HS_L1, PH_HS_L2,
    PH_SKIP_RANDOM,
    PH_SID_LEN, PH_SKIP_SID,
    PH_CS_L0, PH_CS_L1, PH_SKIP_CS,
    PH_CM_LEN, PH_SKIP_CM,
    PH_EX_L0, PH_EX_L1,
    PH_ET0, PH_ET1, PH_EL0, PH_EL1, PH_SKIP_EXT,
    PH_SL0, PH_SL1,
    PH_NT, PH_NL0, PH_NL1, PH_NAME, PH_SKIP_NAME,
    PH_IDLE
  } phase_e;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_HELLO = 3'd1,
    ST_REC_LEN   = 3'd2,
    ST_MALFORMED = 3'd3,
    ST_NO_NAME   = 3'd4
  } status_e;

  // outcome register: 0 undecided, 1 found, 2..5 failure (status + 1)
  localparam logic [2:0] OC_NONE  = 3'd0;
  localparam logic [2:0] OC_FOUND = 3'd1;

  localparam logic [7:0]  REC_TYPE_HS  = 8'h16;
  localparam logic [7:0]  REC_MAJOR    = 8'h03;
  localparam logic [7:0]  HS_TYPE_CH   = 8'h01;
  localparam int unsigned RANDOM_SKIP  = 2 + 32;
  localparam logic [14:0] MAX_REC_RST  = 15'd8192;
endpackage
`default_nettype wire

@@ hdl/tls_client_hello_sni_extractor_top.sv @@
// Top level: byte-stream TLS ClientHello parser that extracts the SNI hostname.
`default_nettype none
// One record byte per beat, one beat per cycle while the output is not stalled.
// Each byte is parsed by a single pass of the phase FSM on the accepted byte,
// and the result (if any) lands in a one-deep output register; the input side
// stays ready while that register is empty or being drained in the same cycle,
// so a result shows in the cycle after its byte and throughput is one byte per
// clock with no stalls of its own. Results appear only for name characters,
// name verdicts and the last byte of a record (status). After the last byte
// all parse state returns to reset; max_rec_q keeps its value. No clearing pass after reset.
module tls_client_hello_sni_extractor_top #(
  parameter int unsigned HOSTNAME_MAX  = 253,
  parameter int unsigned POSITION_BITS = 15
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sni_pkg::sni_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output sni_pkg::sni_out_t      out_data_o,
  input  wire logic              cfg_we_i,
  input  wire logic [14:0]       cfg_wdata_i
);
  import sni_pkg::*;

  localparam int unsigned PB = POSITION_BITS;
  // Compare width: positions plus a 16-bit length plus carry room.
  localparam int unsigned CW = 18;
  localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

  phase_e        phase_q, phase_d;
  logic [PB-1:0] pos_q, pos_d;
  logic [PB-1:0] rec_end_q, rec_end_d;
  logic [24:0]   hello_end_q, hello_end_d;
  logic [PB-1:0] exts_end_q, exts_end_d;
  logic [PB-1:0] ext_end_q, ext_end_d;
  logic [PB-1:0] list_end_q, list_end_d;
  logic [16:0]   acc_q, acc_d;   // bit 16: type flag, low bits: length bytes
  logic [15:0]   skip_q, skip_d;
  logic [15:0]   nrem_q, nrem_d;
  logic [3:0]    flags_q, flags_d;
  logic [2:0]    oc_q, oc_d;
  logic [14:0]   max_rec_q;
  logic          first_q, first_d;  // start-of-name marker

  logic          out_valid_q;
  sni_out_t      out_q, res;
  logic          res_v;

  logic          fire;
  logic [7:0]    b;
  logic [CW-1:0] c;       // current position, widened
  logic [CW-1:0] he;      // hello_end clipped to compare width
  logic [15:0]   v16;
  logic [CW-1:0] v;
  logic          go_en;
  phase_e        go_ph;
  logic [24:0]   hsum;
  logic          is_host;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign b           = in_data_i.record_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_rec_q <= MAX_REC_RST;
    else if (cfg_we_i) max_rec_q <= cfg_wdata_i;
  end

  function automatic phase_e after_skip(phase_e p);
    phase_e r;
    case (p)
      PH_SKIP_RANDOM: r = PH_SID_LEN;
      PH_SKIP_SID:    r = PH_CS_L0;
      PH_SKIP_CS:     r = PH_CM_LEN;
      PH_SKIP_CM:     r = PH_EX_L0;
      PH_SKIP_EXT:    r = PH_ET0;
      default:        r = PH_NT;
    endcase
    return r;
  endfunction

  always_comb begin
    pos_d = (pos_q != POS_MAX) ? pos_q + 1'b1 : POS_MAX;
    c     = CW'(pos_d);
    // hello_end beyond the record is rejected at parse time, so clip safely
    he    = (hello_end_q > 25'((1 << CW) - 1)) ? {CW{1'b1}} : hello_end_q[CW-1:0];
    is_host = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
              (b >= "0" && b <= "9") || b == "-" || b == ".";
    hsum  = 25'd9 + 25'({acc_q[15:0], b});
  end

  // Next-state pass: one byte through the phase FSM.
  always_comb begin
    phase_d     = phase_q;
    rec_end_d   = rec_end_q;
    hello_end_d = hello_end_q;
    exts_end_d  = exts_end_q;
    ext_end_d   = ext_end_q;
    list_end_d  = list_end_q;
    acc_d       = acc_q;
    skip_d      = skip_q;
    nrem_d      = nrem_q;
    flags_d     = flags_q;
    oc_d        = oc_q;
    first_d     = first_q;
    res         = '0;
    go_en       = 1'b0;
    go_ph       = PH_IDLE;
    v16         = {acc_q[7:0], b};
    v           = CW'(v16);
    if (oc_q == OC_NONE) begin
      case (phase_q)
        PH_H0: begin
          if (b != REC_TYPE_HS) oc_d = 3'(ST_NOT_HELLO) + 3'd1;
          else phase_d = PH_H1;
        end
        PH_H1: begin
          if (b != REC_MAJOR) oc_d = 3'(ST_NOT_HELLO) + 3'd1;
          else phase_d = PH_H2;
        end
        PH_H2: phase_d = PH_H3;
        PH_H3: begin
          acc_d = 17'(b);
          phase_d = PH_H4;
        end
        PH_H4: begin
          if (v16 < 16'd4 || 18'd5 + v > 18'(max_rec_q) || 18'd5 + v > 18'(POS_MAX))
            oc_d = 3'(ST_REC_LEN) + 3'd1;
          else begin
            rec_end_d = PB'(18'd5 + v);
            phase_d = PH_HS_TYPE;
          end
        end
        PH_HS_TYPE: begin
          if (b != HS_TYPE_CH) oc_d = 3'(ST_NOT_HELLO) + 3'd1;
          else phase_d = PH_HS_L0;
        end
        PH_HS_L0: begin
          acc_d = 17'(b);
          phase_d = PH_HS_L1;
        end
        PH_HS_L1: begin
          acc_d = 17'({acc_q[7:0], b});
          phase_d = PH_HS_L2;
        end
        PH_HS_L2: begin
          acc_d = {1'b0, acc_q[15:0]};
          hello_end_d = hsum;
          if (hsum > 25'(rec_end_q) || hsum < 25'(9 + RANDOM_SKIP))
            oc_d = 3'(ST_MALFORMED) + 3'd1;
          else begin
            skip_d = 16'(RANDOM_SKIP);
            phase_d = PH_SKIP_RANDOM;
          end
        end
        PH_SKIP_RANDOM, PH_SKIP_SID, PH_SKIP_CS, PH_SKIP_CM, PH_SKIP_EXT,
        PH_SKIP_NAME: begin
          skip_d = (skip_q != 16'd0) ? skip_q - 16'd1 : 16'd0;
          if (skip_d == 16'd0) begin
            go_en = 1'b1;
            go_ph = after_skip(phase_q);
          end
        end
        PH_SID_LEN, PH_CM_LEN: begin
          if (c + CW'(b) + 18'd2 > he) oc_d = 3'(ST_MALFORMED) + 3'd1;
          else if (b == 8'd0) begin
            go_en = 1'b1;
            go_ph = (phase_q == PH_SID_LEN) ? PH_CS_L0 : PH_EX_L0;
          end else begin
            skip_d  = 16'(b);
            phase_d = (phase_q == PH_SID_LEN) ? PH_SKIP_SID : PH_SKIP_CM;
          end
        end
        PH_CS_L0, PH_EX_L0, PH_ET0, PH_SL0: begin
          acc_d = 17'(b);
          case (phase_q)
            PH_CS_L0: phase_d = PH_CS_L1;
            PH_EX_L0: phase_d = PH_EX_L1;
            PH_ET0:   phase_d = PH_ET1;
            default:  phase_d = PH_SL1;
          endcase
        end
        PH_CS_L1: begin
          if (c + v + 18'd1 > he) oc_d = 3'(ST_MALFORMED) + 3'd1;
          else if (v16 == 16'd0) begin
            go_en = 1'b1;
            go_ph = PH_CM_LEN;
          end else begin
            skip_d = v16;
            phase_d = PH_SKIP_CS;
          end
        end
        PH_EX_L1: begin
          if (c > he || v > he - c) oc_d = 3'(ST_MALFORMED) + 3'd1;
          else begin
            exts_end_d = PB'(c + v);
            go_en = 1'b1;
            go_ph = PH_ET0;
          end
        end
        PH_ET1: begin
          acc_d = (v16 == 16'd0) ? 17'h10000 : 17'h0;
          phase_d = PH_EL0;
        end
        PH_EL0, PH_NL0: begin
          acc_d = {acc_q[16], b, 8'h00};
          phase_d = (phase_q == PH_EL0) ? PH_EL1 : PH_NL1;
        end
        PH_EL1: begin
          v16 = {acc_q[15:8], b};
          v   = CW'(v16);
          if (c > CW'(exts_end_q) || v > CW'(exts_end_q) - c)
            oc_d = 3'(ST_MALFORMED) + 3'd1;
          else begin
            ext_end_d = PB'(c + v);
            if (acc_q[16]) begin
              if (c + 18'd2 > c + v) oc_d = 3'(ST_MALFORMED) + 3'd1;
              else phase_d = PH_SL0;
            end else if (v16 == 16'd0) begin
              go_en = 1'b1;
              go_ph = PH_ET0;
            end else begin
              skip_d = v16;
              phase_d = PH_SKIP_EXT;
            end
          end
        end
        PH_SL1: begin
          if (c > CW'(ext_end_q) || v > CW'(ext_end_q) - c)
            oc_d = 3'(ST_MALFORMED) + 3'd1;
          else begin
            list_end_d = PB'(c + v);
            go_en = 1'b1;
            go_ph = PH_NT;
          end
        end
        PH_NT: begin
          acc_d = (b == 8'd0) ? 17'h10000 : 17'h0;
          phase_d = PH_NL0;
        end
        PH_NL1: begin
          v16 = {acc_q[15:8], b};
          v   = CW'(v16);
          if (c > CW'(list_end_q) || v > CW'(list_end_q) - c)
            oc_d = 3'(ST_MALFORMED) + 3'd1;
          else if (acc_q[16]) begin
            nrem_d  = v16;
            flags_d = (v16 == 16'd0 || v16 > 16'(HOSTNAME_MAX)) ? 4'd8 : 4'd0;
            first_d = 1'b1;
            if (v16 == 16'd0) begin
              res.name_done = 1'b1;
              go_en = 1'b1;
              go_ph = PH_NT;
            end else phase_d = PH_NAME;
          end else if (v16 == 16'd0) begin
            go_en = 1'b1;
            go_ph = PH_NT;
          end else begin
            skip_d = v16;
            phase_d = PH_SKIP_NAME;
          end
        end
        PH_NAME: begin
          res.char_valid = 1'b1;
          res.name_char  = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
          flags_d = flags_q;
          if (first_q) begin
            if (b == ".") flags_d[1] = 1'b1;
            first_d = 1'b0;
          end
          if (!is_host) flags_d[0] = 1'b1;
          flags_d[2] = (b == ".");
          nrem_d = (nrem_q != 16'd0) ? nrem_q - 16'd1 : 16'd0;
          if (nrem_d == 16'd0) begin
            res.name_done = 1'b1;
            res.name_ok   = (flags_d == 4'd0);
            if (flags_d == 4'd0) begin
              oc_d = OC_FOUND;
              phase_d = PH_IDLE;
            end else begin
              go_en = 1'b1;
              go_ph = PH_NT;
            end
          end
        end
        default: ;
      endcase
      if (oc_d != OC_NONE) phase_d = PH_IDLE;
      // Bound checks made on entry to a phase
      if (go_en) begin
        if (go_ph == PH_SID_LEN && c >= he)
          oc_d = 3'(ST_MALFORMED) + 3'd1;
        else if (go_ph == PH_ET0 && c + 18'd4 > CW'(exts_end_d))
          oc_d = 3'(ST_NO_NAME) + 3'd1;
        else if (go_ph == PH_NT && c + 18'd3 > CW'(list_end_d))
          oc_d = 3'(ST_NO_NAME) + 3'd1;
        phase_d = (oc_d != OC_NONE) ? PH_IDLE : go_ph;
      end
    end

    if (in_data_i.last_byte) begin
      res.record_done = 1'b1;
      if (oc_d >= 3'd2) res.status = oc_d - 3'd1;
      else if (rec_end_d == '0 || pos_d != rec_end_d) res.status = ST_REC_LEN;
      else if (oc_d == OC_FOUND) res.status = ST_FOUND;
      else res.status = ST_MALFORMED;
    end
    res_v = res.char_valid || res.name_done || res.record_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_H0; pos_q <= '0; rec_end_q <= '0; hello_end_q <= '0;
      exts_end_q <= '0; ext_end_q <= '0; list_end_q <= '0; acc_q <= '0;
      skip_q <= '0; nrem_q <= '0; flags_q <= '0; oc_q <= OC_NONE;
      first_q <= 1'b0;
    end else if (fire) begin
      if (in_data_i.last_byte) begin
        phase_q <= PH_H0; pos_q <= '0; rec_end_q <= '0; hello_end_q <= '0;
        exts_end_q <= '0; ext_end_q <= '0; list_end_q <= '0; acc_q <= '0;
        skip_q <= '0; nrem_q <= '0; flags_q <= '0; oc_q <= OC_NONE;
        first_q <= 1'b0;
      end else begin
        phase_q <= phase_d; pos_q <= pos_d; rec_end_q <= rec_end_d;
        hello_end_q <= hello_end_d; exts_end_q <= exts_end_d;
        ext_end_q <= ext_end_d; list_end_q <= list_end_d; acc_q <= acc_d;
        skip_q <= skip_d; nrem_q <= nrem_d; flags_q <= flags_d; oc_q <= oc_d;
        first_q <= first_d;
      end
    end
  end

  // Output register: refilled whenever it is empty or being drained.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (in_ready_o) out_valid_q <= fire && res_v;
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_v) out_q <= res;
  end
endmodule
`default_nettype wire

@@ hdl/sni_checker.sv @@
// Port-level checker for the SNI extractor, with its bind.
`default_nettype none
`include "tls_client_hello_sni_extractor_top_defines.svh"
module sni_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire sni_pkg::sni_out_t out_data_o
);
  import sni_pkg::*;
  `SNI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result dropped while stalled")
  `SNI_ASSERT_IMPL(a_ready_free, clk_i, rst_ni, !out_valid_o, in_ready_o, "input stalled with empty output")
  `SNI_ASSERT_IMPL(a_status_range, clk_i, rst_ni, out_valid_o && out_data_o.record_done, out_data_o.status <= 3'(ST_NO_NAME), "status out of range")
  `SNI_ASSERT_IMPL(a_ok_needs_done, clk_i, rst_ni, out_valid_o && out_data_o.name_ok, out_data_o.name_done, "name_ok without name_done")
endmodule

bind tls_client_hello_sni_extractor_top sni_checker u_sni_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
);
`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for the TLS ClientHello SNI extractor: directed and random records vs a predictor.
`timescale 1ns / 1ps
module testbench;
  import sni_pkg::*;

  typedef logic [7:0] octet_t;

  localparam int unsigned POS_MAX   = 32767;
  localparam int unsigned HOST_MAX  = 253;
  localparam int unsigned STALL_MAX = 4000;
  localparam int unsigned DRAIN_CYC = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  sni_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  sni_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [14:0] cfg_wdata_i = '0;

  tls_client_hello_sni_extractor_top i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Idle rates in percent; changed per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned fail_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned beats_sent = 0;

  // ---------------------------------------------------------------------------
  // Parser shadow: mirrors the extractor state byte by byte.
  // ---------------------------------------------------------------------------
  int unsigned max_rec;
  phase_e      walk_phase;
  int unsigned pos, rec_end, hello_end, exts_end, ext_end, list_end;
  int unsigned acc, skip_rem, name_rem, name_flags, outcome;

  sni_out_t expected_results[$];

  function void clear_walk();
    walk_phase = PH_H0;
    pos = 0; rec_end = 0; hello_end = 0; exts_end = 0; ext_end = 0; list_end = 0;
    acc = 0; skip_rem = 0; name_rem = 0; name_flags = 0; outcome = OC_NONE;
  endfunction

  function void latch_fail(status_e st);
    outcome = int'(st) + 1;
    walk_phase = PH_IDLE;
  endfunction

  // Phase entry with the bound check tied to that phase's start.
  function void enter(phase_e p);
    if (p == PH_SID_LEN && pos >= hello_end) latch_fail(ST_MALFORMED);
    else if (p == PH_ET0 && pos + 4 > exts_end) latch_fail(ST_NO_NAME);
    else if (p == PH_NT && pos + 3 > list_end) latch_fail(ST_NO_NAME);
    else walk_phase = p;
  endfunction

  function phase_e resume_of(phase_e p);
    case (p)
      PH_SKIP_RANDOM: return PH_SID_LEN;
      PH_SKIP_SID:    return PH_CS_L0;
      PH_SKIP_CS:     return PH_CM_LEN;
      PH_SKIP_CM:     return PH_EX_L0;
      PH_SKIP_EXT:    return PH_ET0;
      default:        return PH_NT;
    endcase
  endfunction

  function void skip_or_enter(int unsigned n, phase_e p);
    if (n == 0) enter(resume_of(p));
    else begin
      skip_rem = n & 32'hFFFF;
      walk_phase = p;
    end
  endfunction

  function bit is_host_char(int unsigned b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
           (b >= "0" && b <= "9") || b == "-" || b == ".";
  endfunction

  // Advances the shadow by one byte and queues the result it causes, if any.
  function void predict_byte(octet_t byte_in, logic last);
    int unsigned b, v, ch, st;
    bit cv, nd, nok, rd;
    sni_out_t r;
    b = byte_in; ch = 0; st = 0; cv = 0; nd = 0; nok = 0; rd = 0;
    pos = (pos < POS_MAX) ? pos + 1 : POS_MAX;
    if (outcome == OC_NONE) begin
      case (walk_phase)
        PH_H0: if (b != REC_TYPE_HS) latch_fail(ST_NOT_HELLO); else walk_phase = PH_H1;
        PH_H1: if (b != REC_MAJOR) latch_fail(ST_NOT_HELLO); else walk_phase = PH_H2;
        PH_H2: walk_phase = PH_H3;
        PH_H3: begin acc = b; walk_phase = PH_H4; end
        PH_H4: begin
          v = ((acc & 'hFF) << 8) | b;
          if (v < 4 || 5 + v > max_rec || 5 + v > POS_MAX) latch_fail(ST_REC_LEN);
          else begin rec_end = 5 + v; walk_phase = PH_HS_TYPE; end
        end
        PH_HS_TYPE: if (b != HS_TYPE_CH) latch_fail(ST_NOT_HELLO); else walk_phase = PH_HS_L0;
        PH_HS_L0: begin acc = b; walk_phase = PH_HS_L1; end
        PH_HS_L1: begin acc = ((acc & 'hFF) << 8) | b; walk_phase = PH_HS_L2; end
        PH_HS_L2: begin
          acc = ((acc & 'hFFFF) << 8) | b;
          hello_end = 9 + acc;
          if (hello_end > rec_end || hello_end < 9 + RANDOM_SKIP) latch_fail(ST_MALFORMED);
          else skip_or_enter(RANDOM_SKIP, PH_SKIP_RANDOM);
        end
        PH_SKIP_RANDOM, PH_SKIP_SID, PH_SKIP_CS, PH_SKIP_CM, PH_SKIP_EXT,
        PH_SKIP_NAME: begin
          skip_rem = (skip_rem > 0) ? skip_rem - 1 : 0;
          if (skip_rem == 0) enter(resume_of(walk_phase));
        end
        PH_SID_LEN:
          if (pos + b + 2 > hello_end) latch_fail(ST_MALFORMED);
          else skip_or_enter(b, PH_SKIP_SID);
        PH_CS_L0: begin acc = b; walk_phase = PH_CS_L1; end
        PH_CS_L1: begin
          v = ((acc & 'hFF) << 8) | b;
          if (pos + v + 1 > hello_end) latch_fail(ST_MALFORMED);
          else skip_or_enter(v, PH_SKIP_CS);
        end
        PH_CM_LEN:
          if (pos + b + 2 > hello_end) latch_fail(ST_MALFORMED);
          else skip_or_enter(b, PH_SKIP_CM);
        PH_EX_L0: begin acc = b; walk_phase = PH_EX_L1; end
        PH_EX_L1: begin
          v = ((acc & 'hFF) << 8) | b;
          if (pos > hello_end || v > hello_end - pos) latch_fail(ST_MALFORMED);
          else begin exts_end = pos + v; enter(PH_ET0); end
        end
        PH_ET0: begin acc = b; walk_phase = PH_ET1; end
        PH_ET1: begin
          v = ((acc & 'hFF) << 8) | b;
          acc = (v == 0) ? 'h10000 : 0;
          walk_phase = PH_EL0;
        end
        PH_EL0: begin acc = (acc & 'h10000) | (b << 8); walk_phase = PH_EL1; end
        PH_EL1: begin
          v = (acc & 'hFF00) | b;
          if (pos > exts_end || v > exts_end - pos) latch_fail(ST_MALFORMED);
          else begin
            ext_end = pos + v;
            if ((acc & 'h10000) != 0) begin
              if (pos + 2 > ext_end) latch_fail(ST_MALFORMED);
              else walk_phase = PH_SL0;
            end else skip_or_enter(v, PH_SKIP_EXT);
          end
        end
        PH_SL0: begin acc = b; walk_phase = PH_SL1; end
        PH_SL1: begin
          v = ((acc & 'hFF) << 8) | b;
          if (pos > ext_end || v > ext_end - pos) latch_fail(ST_MALFORMED);
          else begin list_end = pos + v; enter(PH_NT); end
        end
        PH_NT: begin acc = (b == 0) ? 'h10000 : 0; walk_phase = PH_NL0; end
        PH_NL0: begin acc = (acc & 'h10000) | (b << 8); walk_phase = PH_NL1; end
        PH_NL1: begin
          v = (acc & 'hFF00) | b;
          if (pos > list_end || v > list_end - pos) latch_fail(ST_MALFORMED);
          else if ((acc & 'h10000) != 0) begin
            name_rem = v;
            name_flags = (v == 0 || v > HOST_MAX) ? 8 : 0;
            acc = 1;
            if (v == 0) begin nd = 1; enter(PH_NT); end
            else walk_phase = PH_NAME;
          end else skip_or_enter(v, PH_SKIP_NAME);
        end
        PH_NAME: begin
          cv = 1;
          ch = (b >= "A" && b <= "Z") ? b + 32 : b;
          if ((acc & 1) != 0) begin
            if (b == ".") name_flags |= 2;
            acc = 0;
          end
          if (!is_host_char(b)) name_flags |= 1;
          name_flags = (name_flags & 'hB) | ((b == ".") ? 4 : 0);
          name_rem = (name_rem > 0) ? name_rem - 1 : 0;
          if (name_rem == 0) begin
            nd = 1;
            nok = (name_flags == 0);
            if (nok) begin outcome = OC_FOUND; walk_phase = PH_IDLE; end
            else enter(PH_NT);
          end
        end
        default: ;
      endcase
    end
    if (last) begin
      rd = 1;
      if (outcome >= 2) st = outcome - 1;
      else if (rec_end == 0 || pos != rec_end) st = ST_REC_LEN;
      else if (outcome == OC_FOUND) st = ST_FOUND;
      else st = ST_MALFORMED;
      clear_walk();
    end
    if (cv || nd || rd) begin
      r.name_char   = ch[7:0];
      r.char_valid  = cv;
      r.name_done   = nd;
      r.name_ok     = nok;
      r.record_done = rd;
      r.status      = st[2:0];
      expected_results.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker, receiver stalls and watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    sni_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat %h", out_data_o);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_data_o.name_char !== e.name_char) begin
          $error("name_char exp %h got %h", e.name_char, out_data_o.name_char);
          fail_count++;
        end
        if (out_data_o.char_valid !== e.char_valid) begin
          $error("char_valid exp %b got %b", e.char_valid, out_data_o.char_valid);
          fail_count++;
        end
        if (out_data_o.name_done !== e.name_done) begin
          $error("name_done exp %b got %b", e.name_done, out_data_o.name_done);
          fail_count++;
        end
        if (out_data_o.name_ok !== e.name_ok) begin
          $error("name_ok exp %b got %b", e.name_ok, out_data_o.name_ok);
          fail_count++;
        end
        if (out_data_o.record_done !== e.record_done) begin
          $error("record_done exp %b got %b", e.record_done, out_data_o.record_done);
          fail_count++;
        end
        if (out_data_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_data_o.status);
          fail_count++;
        end
      end
    end
  end

  // Any accepted beat on either side resets the stall count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_MAX) begin
      $display("tls_client_hello_sni_extractor_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  // Valid stays up across back-to-back beats; it only drops for a gap.
  task automatic send_beat(octet_t b, logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{record_byte: b, last_byte: last};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_byte(b, last);
    beats_sent++;
  endtask

  task automatic send_record(octet_t rec[$]);
    foreach (rec[i]) send_beat(rec[i], i == rec.size() - 1);
  endtask

  // Drain all results, then allow for a byte still in flight that had none.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_max_record(int unsigned v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[14:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    max_rec = v & 'h7FFF;
  endtask

  // Pool of server names feeding the next ClientHello.
  octet_t      name_bytes[$];
  int unsigned name_lens[$];
  int unsigned name_types[$];

  task automatic add_name(int unsigned t, string s);
    name_types.push_back(t);
    name_lens.push_back(s.len());
    for (int i = 0; i < s.len(); i++) name_bytes.push_back(s[i]);
  endtask

  task automatic add_random_name();
    string alpha;
    int unsigned n, sel;
    alpha = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-.";
    sel = $urandom_range(99);
    if (sel < 5) n = 0;
    else if (sel < 8) n = $urandom_range(253, 255);
    else if (sel < 20) n = $urandom_range(13, 30);
    else n = $urandom_range(1, 12);
    name_types.push_back(($urandom_range(99) < 85) ? 0 : $urandom_range(1, 255));
    name_lens.push_back(n);
    for (int i = 0; i < n; i++)
      if ($urandom_range(99) < 4) name_bytes.push_back(octet_t'($urandom_range(255)));
      else name_bytes.push_back(alpha[$urandom_range(alpha.len() - 1)]);
  endtask

  task automatic add_other_ext(ref octet_t q[$]);
    int unsigned n;
    n = $urandom_range(0, 6);
    q.push_back(octet_t'($urandom_range(255)));
    q.push_back(octet_t'($urandom_range(1, 255)));
    q.push_back(8'h00);
    q.push_back(octet_t'(n));
    repeat (n) q.push_back(octet_t'($urandom_range(255)));
  endtask

  // Wraps the name pool in a well-formed ClientHello record; empties the pool.
  task automatic build_hello(output octet_t rec[$], input bit with_sni);
    octet_t lst[$], exts[$], body[$];
    int unsigned k, n;
    k = 0;
    foreach (name_lens[i]) begin
      lst.push_back(octet_t'(name_types[i]));
      lst.push_back(octet_t'(name_lens[i] >> 8));
      lst.push_back(octet_t'(name_lens[i]));
      repeat (name_lens[i]) begin lst.push_back(name_bytes[k]); k++; end
    end
    name_bytes.delete(); name_lens.delete(); name_types.delete();
    if ($urandom_range(1)) add_other_ext(exts);
    if (with_sni) begin
      exts.push_back(8'h00); exts.push_back(8'h00);
      exts.push_back(octet_t'((lst.size() + 2) >> 8));
      exts.push_back(octet_t'(lst.size() + 2));
      exts.push_back(octet_t'(lst.size() >> 8));
      exts.push_back(octet_t'(lst.size()));
      foreach (lst[i]) exts.push_back(lst[i]);
    end
    if ($urandom_range(1)) add_other_ext(exts);
    body.push_back(REC_MAJOR); body.push_back(8'h03);
    repeat (32) body.push_back(octet_t'($urandom_range(255)));
    n = $urandom_range(0, 4);
    body.push_back(octet_t'(n));
    repeat (n) body.push_back(octet_t'($urandom_range(255)));
    n = 2 * $urandom_range(1, 3);
    body.push_back(8'h00); body.push_back(octet_t'(n));
    repeat (n) body.push_back(octet_t'($urandom_range(255)));
    body.push_back(8'h01); body.push_back(8'h00);
    body.push_back(octet_t'(exts.size() >> 8)); body.push_back(octet_t'(exts.size()));
    foreach (exts[i]) body.push_back(exts[i]);
    rec = {REC_TYPE_HS, REC_MAJOR, 8'h01,
           octet_t'((body.size() + 4) >> 8), octet_t'(body.size() + 4),
           HS_TYPE_CH, 8'h00, octet_t'(body.size() >> 8), octet_t'(body.size())};
    foreach (body[i]) rec.push_back(body[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  task automatic test_names();
    octet_t rec[$];
    string long_name;
    add_name(0, "Example.COM");
    build_hello(rec, 1); send_record(rec);
    // empty name, other name type, leading dot, bad char, trailing dot, then a good one
    add_name(0, ""); add_name(7, "skip.me"); add_name(0, ".lead");
    add_name(0, "a_b"); add_name(0, "tail."); add_name(0, "Ok-1.NET");
    build_hello(rec, 1); send_record(rec);
    // longest legal name; longer ones come from the random names
    long_name = "";
    repeat (253) long_name = {long_name, "x"};
    add_name(0, long_name);
    build_hello(rec, 1); send_record(rec);
    // no server_name extension at all
    build_hello(rec, 0); send_record(rec);
    // record cut short before its end, which can end it inside the name
    add_name(0, "truncated.host");
    build_hello(rec, 1);
    rec = rec[0:rec.size() - 6];
    send_record(rec);
  endtask

  task automatic test_headers();
    octet_t rec[$];
    send_record('{8'h17, 8'h03, 8'h01, 8'h00, 8'h04, 8'h01});
    send_record('{REC_TYPE_HS, 8'h02});
    send_record('{REC_TYPE_HS, REC_MAJOR, 8'h01, 8'h00, 8'h03, 8'h01, 8'h00, 8'h00});
    send_record('{REC_TYPE_HS, REC_MAJOR, 8'h01, 8'h00, 8'h04,
                  8'h02, 8'h00, 8'h00, 8'h00});
    send_record('{REC_TYPE_HS, REC_MAJOR});
    send_record('{8'hFF});
    add_name(0, "host");
    build_hello(rec, 1);
    rec.push_back(8'h00);
    send_record(rec);
  endtask

  task automatic test_record_limit();
    // smallest setting: a 9-byte record fits, a 10-byte one does not
    write_max_record(9);
    send_record('{REC_TYPE_HS, REC_MAJOR, 8'h01, 8'h00, 8'h04,
                  HS_TYPE_CH, 8'h00, 8'h00, 8'h00});
    send_record('{REC_TYPE_HS, REC_MAJOR, 8'h01, 8'h00, 8'h05, HS_TYPE_CH, 8'h00});
    write_max_record(16389);
    send_record('{REC_TYPE_HS, REC_MAJOR, 8'h01, 8'h40, 8'h00, HS_TYPE_CH});
    send_record('{REC_TYPE_HS, REC_MAJOR, 8'h01, 8'h40, 8'h01, HS_TYPE_CH});
    send_record('{REC_TYPE_HS, REC_MAJOR, 8'h01, 8'hFF, 8'hFF, HS_TYPE_CH});
    write_max_record(100);
    send_record('{REC_TYPE_HS, REC_MAJOR, 8'h01, 8'h00, 8'h5F, HS_TYPE_CH});
    send_record('{REC_TYPE_HS, REC_MAJOR, 8'h01, 8'h00, 8'h60, HS_TYPE_CH});
  endtask

  // Mostly well-formed hellos with random names, some damaged, some pure noise.
  task automatic test_random(int unsigned beats);
    octet_t rec[$];
    int unsigned stop_at, sel, k;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        rec.delete();
        repeat ($urandom_range(1, 20)) rec.push_back(octet_t'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(0, 3)) add_random_name();
        build_hello(rec, $urandom_range(99) < 90);
        if (sel < 20) begin
          k = $urandom_range(rec.size() - 1);
          rec[k] = octet_t'($urandom_range(255));
        end else if (sel < 26) begin
          rec = rec[0:$urandom_range(rec.size() - 1)];
        end else if (sel < 30) begin
          repeat ($urandom_range(1, 3)) rec.push_back(octet_t'($urandom_range(255)));
        end
      end
      send_record(rec);
    end
  endtask

  initial begin
    max_rec = MAX_REC_RST;
    clear_walk();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 33; recv_idle_pct = 69;
    test_names();
    test_headers();
    test_record_limit();
    write_max_record($urandom_range(200, 16389));
    test_random(40);

    send_idle_pct = 69; recv_idle_pct = 33;
    write_max_record($urandom_range(200, 16389));
    test_random(60);

    send_idle_pct = 0; recv_idle_pct = 0;
    write_max_record(MAX_REC_RST);
    test_random(60);

    settle();
    if (fail_count == 0) $display("tls_client_hello_sni_extractor_top regression: pass");
    else $display("tls_client_hello_sni_extractor_top regression: fail");
    $finish;
  end
endmodule
